>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by triangle_face_normal_top.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths and defaults shared by the triangle face normal files.
// ----------------------------------------------------------------------------
package tfn_pkg;

   localparam int unsigned COORD_WIDTH_DEF  = 32;
   localparam int unsigned NORMAL_FRAC_DEF  = 16;
   localparam int unsigned FIELD_WIDTH      = 32;
   localparam int unsigned NUM_IN_FIELDS    = 9;
   localparam int unsigned REQ_DATA_WIDTH   = FIELD_WIDTH * NUM_IN_FIELDS;
   // The largest normalized magnitude keeps its top set bit at bit 30.
   localparam int unsigned NORM_BITS        = 31;
   localparam int unsigned SUM_WIDTH        = 64;
   localparam int unsigned ROOT_WIDTH       = SUM_WIDTH / 2;

endpackage

>>> design/triangle_face_normal_top.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Unit face normal of a triangle from three signed fixed-point vertices.
// ----------------------------------------------------------------------------
// The block takes one triangle per word and returns one normal per word,
// accepting a new word every cycle while the result is not stalled. The
// pipeline holds the edge, product, normalization and sum of squares stages,
// a 32-stage square root pipeline, a divider pipeline of one stage per
// quotient bit and the output register. A stalled result stops the whole
// pipeline in place. A triangle whose cross product is zero returns a zero
// normal with the degenerate flag set.
`include "assert_macros.svh"

module triangle_face_normal_top #(
   parameter int unsigned COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
   parameter int unsigned NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_DEF,
   localparam int unsigned NORMAL_WIDTH    = NORMAL_FRAC_BITS + 2,
   localparam int unsigned RSP_DATA_WIDTH  = ((3 * NORMAL_WIDTH + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
   // vert2_x, vert2_y, vert2_z, 32 bits each
   input  logic [tfn_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // normal_x, normal_y, normal_z, then zero fill
   output logic [RSP_DATA_WIDTH-1:0]          rsp_tdata,
   // degenerate
   output logic                               rsp_tuser
);
   import tfn_pkg::*;

   localparam int unsigned EW    = COORD_WIDTH + 1;
   localparam int unsigned PW    = 2 * EW;
   localparam int unsigned MP    = ((PW + 7) / 8) * 8;
   localparam int unsigned NCH   = MP / 8;
   localparam int unsigned CZW   = $clog2(NCH);
   localparam int unsigned SQW   = 2 * NORM_BITS;
   localparam int unsigned NUMW  = NORM_BITS + NORMAL_FRAC_BITS + 1;
   localparam int unsigned QW    = NORMAL_FRAC_BITS + 1;
   localparam int unsigned SIDEW = 3 * NORM_BITS + 4;
   localparam logic [QW-1:0] ONE_Q = QW'(1) << NORMAL_FRAC_BITS;
   localparam logic signed [NORMAL_WIDTH-1:0] ONE_N = NORMAL_WIDTH'(1) << NORMAL_FRAC_BITS;

   // Count of all-zero bytes above the leading set byte.
   function automatic logic [CZW-1:0] lead_bytes(input logic [MP-1:0] w);
      logic [CZW-1:0] n;
      logic           hit;
      n   = '0;
      hit = 1'b0;
      for (int i = NCH - 1; i >= 0; i--) begin
         if (!hit) begin
            if (|w[i*8 +: 8]) hit = 1'b1;
            else n = n + 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [2:0] lead_bits(input logic [7:0] w);
      logic [2:0] n;
      logic       hit;
      n   = '0;
      hit = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (!hit) begin
            if (w[i]) hit = 1'b1;
            else n = n + 1'b1;
         end
      end
      return n;
   endfunction

   logic enable;
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   // Stage 1: edges.
   logic signed [COORD_WIDTH-1:0] vert [NUM_IN_FIELDS];
   logic signed [EW-1:0] ea_ff [3];
   logic signed [EW-1:0] eb_ff [3];
   logic s1_vld_ff;

   for (genvar i = 0; i < NUM_IN_FIELDS; i++) begin : g_vert
      assign vert[i] = $signed(req_tdata[i*FIELD_WIDTH +: COORD_WIDTH]);
   end

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (enable) s1_vld_ff <= req_tvalid;
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            ea_ff[k] <= EW'(vert[3+k]) - EW'(vert[k]);
            eb_ff[k] <= EW'(vert[6+k]) - EW'(vert[k]);
         end
      end
   end

   // Stage 2: the six products of the cross product.
   logic signed [PW-1:0] pa_ff [3];
   logic signed [PW-1:0] pb_ff [3];
   logic s2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (enable) s2_vld_ff <= s1_vld_ff;
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            pa_ff[k] <= ea_ff[(k+1)%3] * eb_ff[(k+2)%3];
            pb_ff[k] <= ea_ff[(k+2)%3] * eb_ff[(k+1)%3];
         end
      end
   end

   // Stage 3: cross components as sign and magnitude.
   logic signed [PW:0] diff [3];
   logic [PW-1:0] mag_ff [3];
   logic [2:0]    neg3_ff;
   logic          s3_vld_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k] = (PW+1)'(pa_ff[k]) - (PW+1)'(pb_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (enable) s3_vld_ff <= s2_vld_ff;
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            neg3_ff[k] <= diff[k][PW];
            mag_ff[k]  <= diff[k][PW] ? PW'(-diff[k]) : PW'(diff[k]);
         end
      end
   end

   // Stage 4: coarse normalization by whole bytes, left-justified.
   logic [MP-1:0]  pad [3];
   logic [MP-1:0]  or4;
   logic [CZW-1:0] coarse;
   logic [MP-1:0]  sh4_ff [3];
   logic [2:0]     neg4_ff;
   logic           degen4_ff;
   logic           s4_vld_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pad[k] = MP'(mag_ff[k]) << (MP - PW);
      end
      or4    = pad[0] | pad[1] | pad[2];
      coarse = lead_bytes(or4);
   end

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (enable) s4_vld_ff <= s3_vld_ff;
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            sh4_ff[k] <= pad[k] << {coarse, 3'b000};
         end
         neg4_ff   <= neg3_ff;
         degen4_ff <= (or4 == '0);
      end
   end

   // Stage 5: fine shift so the largest magnitude tops out at bit 30.
   logic [MP-1:0] or5;
   logic [2:0]    fine;
   logic [MP-1:0] sh5 [3];
   logic [NORM_BITS-1:0] m5_ff [3];
   logic [2:0]    neg5_ff;
   logic          degen5_ff;
   logic          s5_vld_ff;

   always_comb begin
      or5  = sh4_ff[0] | sh4_ff[1] | sh4_ff[2];
      fine = lead_bits(or5[MP-1 -: 8]);
      for (int k = 0; k < 3; k++) begin
         sh5[k] = sh4_ff[k] << fine;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else if (enable) s5_vld_ff <= s4_vld_ff;
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            m5_ff[k] <= sh5[k][MP-1 -: NORM_BITS];
         end
         neg5_ff   <= neg4_ff;
         degen5_ff <= degen4_ff;
      end
   end

   // Stage 6: squares.
   logic [SQW-1:0]       sq_ff [3];
   logic [NORM_BITS-1:0] m6_ff [3];
   logic [2:0]           neg6_ff;
   logic                 degen6_ff;
   logic                 s6_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else if (enable) s6_vld_ff <= s5_vld_ff;
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= m5_ff[k] * m5_ff[k];
         end
         m6_ff     <= m5_ff;
         neg6_ff   <= neg5_ff;
         degen6_ff <= degen5_ff;
      end
   end

   // Stage 7: sum of squares.
   logic [SUM_WIDTH-1:0] sum_ff;
   logic [SIDEW-1:0]     side7_ff;
   logic                 s7_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) s7_vld_ff <= 1'b0;
      else if (enable) s7_vld_ff <= s6_vld_ff;
      if (enable) begin
         sum_ff   <= SUM_WIDTH'(sq_ff[0]) + SUM_WIDTH'(sq_ff[1]) + SUM_WIDTH'(sq_ff[2]);
         side7_ff <= {m6_ff[2], m6_ff[1], m6_ff[0], neg6_ff, degen6_ff};
      end
   end

   // Length of the normalized cross product.
   logic                  rt_vld;
   logic [ROOT_WIDTH-1:0] rt_len;
   logic [SIDEW-1:0]      rt_side;

   tfn_isqrt #(
      .IN_WIDTH   (SUM_WIDTH),
      .SIDE_WIDTH (SIDEW)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (s7_vld_ff),
      .in_value  (sum_ff),
      .in_side   (side7_ff),
      .out_valid (rt_vld),
      .out_root  (rt_len),
      .out_side  (rt_side)
   );

   // Rounded quotients m * 2^F / L, with half of L added first.
   logic [2:0][NUMW-1:0] num;
   logic                 dv_vld;
   logic [2:0][QW-1:0]   dv_quo;
   logic [3:0]           dv_side;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num[k] = (NUMW'(rt_side[4 + k*NORM_BITS +: NORM_BITS]) << NORMAL_FRAC_BITS)
                  + NUMW'(rt_len >> 1);
      end
   end

   tfn_div #(
      .NUM_WIDTH  (NUMW),
      .DEN_WIDTH  (ROOT_WIDTH),
      .QUO_WIDTH  (QW),
      .LANES      (3),
      .SIDE_WIDTH (4)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (rt_vld),
      .in_num    (num),
      .in_den    (rt_len),
      .in_side   (rt_side[3:0]),
      .out_valid (dv_vld),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // Output register: cap, apply sign, zero a degenerate triangle.
   logic signed [NORMAL_WIDTH-1:0] nrm_in [3];
   logic signed [NORMAL_WIDTH-1:0] nrm_ff [3];
   logic                           degen_ff;
   logic                           out_vld_ff;
   logic [QW-1:0]                  capped;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         capped = (dv_quo[k] > ONE_Q) ? ONE_Q : dv_quo[k];
         if (dv_side[0]) begin
            nrm_in[k] = '0;
         end else if (dv_side[1+k]) begin
            nrm_in[k] = -$signed(NORMAL_WIDTH'(capped));
         end else begin
            nrm_in[k] = $signed(NORMAL_WIDTH'(capped));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (enable) out_vld_ff <= dv_vld;
      if (enable) begin
         nrm_ff   <= nrm_in;
         degen_ff <= dv_side[0];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({nrm_ff[2], nrm_ff[1], nrm_ff[0]});
   assign rsp_tuser  = degen_ff;

   `ASSERT_SAME(a_degen_zero, clock, reset, rsp_tvalid && degen_ff,
      nrm_ff[0] == '0 && nrm_ff[1] == '0 && nrm_ff[2] == '0,
      "degenerate word carries a nonzero normal")

   `ASSERT_SAME(a_normal_nonzero, clock, reset, rsp_tvalid && !degen_ff,
      nrm_ff[0] != '0 || nrm_ff[1] != '0 || nrm_ff[2] != '0,
      "nondegenerate word carries a zero normal")

   `ASSERT_SAME(a_x_range, clock, reset, rsp_tvalid,
      nrm_ff[0] <= ONE_N && nrm_ff[0] >= -ONE_N,
      "normal x component exceeds one")

   `ASSERT_NEXT(a_accept_enters, clock, reset, req_tvalid && req_tready,
      s1_vld_ff, "accepted word did not enter the first stage")

endmodule

>>> design/tfn_isqrt.sv
// ----------------------------------------------------------------------------
// tfn_isqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tfn_isqrt #(
   parameter int unsigned IN_WIDTH   = tfn_pkg::SUM_WIDTH,
   parameter int unsigned SIDE_WIDTH = 1,
   localparam int unsigned ROOT_W    = IN_WIDTH / 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  logic [IN_WIDTH-1:0]   in_value,
   input  logic [SIDE_WIDTH-1:0] in_side,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root,
   output logic [SIDE_WIDTH-1:0] out_side
);
   import tfn_pkg::*;

   localparam int unsigned RW = ROOT_W + 3;

   logic [IN_WIDTH-1:0]   x_ff    [ROOT_W-1];
   logic [RW-1:0]         r_ff    [ROOT_W-1];
   logic [ROOT_W-1:0]     q_ff    [ROOT_W];
   logic [SIDE_WIDTH-1:0] side_ff [ROOT_W];
   logic                  vld_ff  [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic [IN_WIDTH-1:0]   x_src;
      logic [RW-1:0]         r_src;
      logic [ROOT_W-1:0]     q_src;
      logic [SIDE_WIDTH-1:0] side_src;
      logic                  vld_src;
      logic [RW-1:0]         trial;
      logic [RW-1:0]         test;
      logic                  take;

      if (s == 0) begin : g_first
         assign x_src    = in_value;
         assign r_src    = '0;
         assign q_src    = '0;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign x_src    = x_ff[s-1];
         assign r_src    = r_ff[s-1];
         assign q_src    = q_ff[s-1];
         assign side_src = side_ff[s-1];
         assign vld_src  = vld_ff[s-1];
      end

      // Bring down the next two bits and try the odd number 4q+1.
      assign trial = {r_src[RW-3:0], x_src[IN_WIDTH-1 -: 2]};
      assign test  = RW'({q_src, 2'b01});
      assign take  = trial >= test;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (enable) begin
            vld_ff[s] <= vld_src;
         end
         if (enable) begin
            q_ff[s]    <= {q_src[ROOT_W-2:0], take};
            side_ff[s] <= side_src;
         end
      end

      if (s < ROOT_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               x_ff[s] <= x_src << 2;
               r_ff[s] <= take ? trial - test : trial;
            end
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = q_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

>>> design/tfn_div.sv
// ----------------------------------------------------------------------------
// tfn_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor.
// ----------------------------------------------------------------------------
module tfn_div #(
   parameter int unsigned NUM_WIDTH  = 48,
   parameter int unsigned DEN_WIDTH  = tfn_pkg::ROOT_WIDTH,
   parameter int unsigned QUO_WIDTH  = 17,
   parameter int unsigned LANES      = 3,
   parameter int unsigned SIDE_WIDTH = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  logic                                 in_valid,
   input  logic [LANES-1:0][NUM_WIDTH-1:0]      in_num,
   input  logic [DEN_WIDTH-1:0]                 in_den,
   input  logic [SIDE_WIDTH-1:0]                in_side,
   output logic                                 out_valid,
   output logic [LANES-1:0][QUO_WIDTH-1:0]      out_quo,
   output logic [SIDE_WIDTH-1:0]                out_side
);
   import tfn_pkg::*;

   localparam int unsigned CMPW = DEN_WIDTH + QUO_WIDTH;

   logic [LANES-1:0][NUM_WIDTH-1:0] rem_ff  [QUO_WIDTH-1];
   logic [DEN_WIDTH-1:0]            den_ff  [QUO_WIDTH-1];
   logic [LANES-1:0][QUO_WIDTH-1:0] q_ff    [QUO_WIDTH];
   logic [SIDE_WIDTH-1:0]           side_ff [QUO_WIDTH];
   logic                            vld_ff  [QUO_WIDTH];

   for (genvar s = 0; s < QUO_WIDTH; s++) begin : g_stage
      localparam int unsigned BIT = QUO_WIDTH - 1 - s;
      logic [LANES-1:0][NUM_WIDTH-1:0] rem_src;
      logic [DEN_WIDTH-1:0]            den_src;
      logic [LANES-1:0][QUO_WIDTH-1:0] q_src;
      logic [SIDE_WIDTH-1:0]           side_src;
      logic                            vld_src;
      logic [CMPW-1:0]                 sub_val;
      logic [LANES-1:0][NUM_WIDTH-1:0] rem_nxt;
      logic [LANES-1:0][QUO_WIDTH-1:0] q_nxt;

      if (s == 0) begin : g_first
         assign rem_src  = in_num;
         assign den_src  = in_den;
         assign q_src    = '0;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign q_src    = q_ff[s-1];
         assign side_src = side_ff[s-1];
         assign vld_src  = vld_ff[s-1];
      end

      assign sub_val = CMPW'(den_src) << BIT;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (CMPW'(rem_src[l]) >= sub_val) begin
               rem_nxt[l] = NUM_WIDTH'(CMPW'(rem_src[l]) - sub_val);
               q_nxt[l]   = {q_src[l][QUO_WIDTH-2:0], 1'b1};
            end else begin
               rem_nxt[l] = rem_src[l];
               q_nxt[l]   = {q_src[l][QUO_WIDTH-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (enable) begin
            vld_ff[s] <= vld_src;
         end
         if (enable) begin
            q_ff[s]    <= q_nxt;
            side_ff[s] <= side_src;
         end
      end

      if (s < QUO_WIDTH - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[s] <= rem_nxt;
               den_ff[s] <= den_src;
            end
         end
      end
   end

   assign out_valid = vld_ff[QUO_WIDTH-1];
   assign out_quo   = q_ff[QUO_WIDTH-1];
   assign out_side  = side_ff[QUO_WIDTH-1];

endmodule

>>> bench/tb_triangle_face_normal_top.sv
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_top
// Streams triangles into the face normal block and checks every normal word
// against a behavioral predictor, with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_triangle_face_normal_top;

   localparam int unsigned NFRAC    = tfn_pkg::NORMAL_FRAC_DEF;
   localparam int unsigned NWIDTH   = NFRAC + 2;
   localparam int unsigned RSP_BITS = ((3 * NWIDTH + 7) / 8) * 8;
   localparam int unsigned REQ_BITS = tfn_pkg::REQ_DATA_WIDTH;
   localparam int          TAIL     = 200;

   typedef struct packed {
      logic [NWIDTH-1:0] nx;
      logic [NWIDTH-1:0] ny;
      logic [NWIDTH-1:0] nz;
      logic              degen;
   } normal_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                rsp_tuser;

   logic [REQ_BITS-1:0] tri_queue[$];
   normal_type          normal_queue[$];
   int                  error_count = 0;
   int                  send_gap;
   int                  recv_gap;
   int                  hold_cycles;
   bit                  calm = 1'b0;
   bit                  hold_go = 1'b0;
   bit                  hold_seen;

   triangle_face_normal_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [127:0] isqrt(input logic [127:0] x);
      logic [127:0] res;
      logic [127:0] bitv;
      res  = 0;
      bitv = 128'd1 << 126;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic normal_type face_normal(input logic [REQ_BITS-1:0] word);
      logic signed [33:0]  v[9];
      logic signed [33:0]  ax, ay, az, bx, by, bz;
      logic signed [71:0]  c[3];
      logic [71:0]         mag[3];
      logic [127:0]        m[3];
      logic [127:0]        sum, len, n;
      logic [NWIDTH-1:0]   o[3];
      normal_type          r;
      int                  top;
      for (int i = 0; i < 9; i++) v[i] = 34'(signed'(word[32*i +: 32]));
      ax = v[3] - v[0]; ay = v[4] - v[1]; az = v[5] - v[2];
      bx = v[6] - v[0]; by = v[7] - v[1]; bz = v[8] - v[2];
      c[0] = 72'(ay) * 72'(bz) - 72'(az) * 72'(by);
      c[1] = 72'(az) * 72'(bx) - 72'(ax) * 72'(bz);
      c[2] = 72'(ax) * 72'(by) - 72'(ay) * 72'(bx);
      top = -1;
      for (int i = 0; i < 3; i++) begin
         mag[i] = c[i] < 0 ? 72'(-c[i]) : 72'(c[i]);
         for (int b = 0; b < 72; b++) if (mag[i][b] && b > top) top = b;
      end
      r = '0;
      if (top < 0) begin
         r.degen = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++)
         m[i] = top > 30 ? 128'(mag[i] >> (top - 30)) : 128'(mag[i]) << (30 - top);
      sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
         n = ((m[i] << NFRAC) + (len >> 1)) / len;
         if (n > (128'd1 << NFRAC)) n = 128'd1 << NFRAC;
         if (c[i] < 0) n = -n;
         o[i] = n[NWIDTH-1:0];
      end
      r.nx = o[0];
      r.ny = o[1];
      r.nz = o[2];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch %s at %0t", msg, $time);
      error_count++;
   endtask

   // Driver: one word per handshake, random idle bursts until the calm phase.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (tri_queue.size() > 0) begin
            req_tdata  <= tri_queue[0];
            normal_queue.insert(normal_queue.size(), face_normal(tri_queue[0]));
            void'(tri_queue.pop_front());
            req_tvalid <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver stalls; a long hold-off lets the pipeline fill and block input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         recv_gap    <= 0;
         hold_cycles <= 0;
         hold_seen   <= 1'b0;
      end else if (hold_go && !hold_seen) begin
         hold_seen   <= 1'b1;
         hold_cycles <= 150;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap   <= recv_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 8);
      end
   end

   // Monitor: each accepted normal word is matched against the oldest prediction.
   always @(posedge clock) begin
      normal_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (normal_queue.size() == 0) begin
            report_mismatch("unexpected normal word");
         end else begin
            want = normal_queue.pop_front();
            if (rsp_tdata[0 +: NWIDTH] !== want.nx)
               report_mismatch($sformatf("normal_x: got %h expected %h",
                                         rsp_tdata[0 +: NWIDTH], want.nx));
            if (rsp_tdata[NWIDTH +: NWIDTH] !== want.ny)
               report_mismatch($sformatf("normal_y: got %h expected %h",
                                         rsp_tdata[NWIDTH +: NWIDTH], want.ny));
            if (rsp_tdata[2*NWIDTH +: NWIDTH] !== want.nz)
               report_mismatch($sformatf("normal_z: got %h expected %h",
                                         rsp_tdata[2*NWIDTH +: NWIDTH], want.nz));
            if (rsp_tuser !== want.degen)
               report_mismatch($sformatf("degenerate: got %b expected %b",
                                         rsp_tuser, want.degen));
         end
      end
   end

   function automatic logic [31:0] rand_coord(input int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
         2: return 32'($signed($urandom_range(0, 2000)) - 1000);
         default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      endcase
   endfunction

   function automatic logic [REQ_BITS-1:0] pack_tri(input logic [31:0] c[9]);
      logic [REQ_BITS-1:0] w;
      for (int i = 0; i < 9; i++) w[32*i +: 32] = c[i];
      return w;
   endfunction

   task automatic enqueue_tri(input logic [31:0] c[9]);
      tri_queue.insert(tri_queue.size(), pack_tri(c));
   endtask

   initial begin
      logic [31:0] c[9];
      int          mode;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: degenerate cases, axis-aligned faces, extreme coordinates.
      foreach (c[i]) c[i] = 32'h0001_0000;
      enqueue_tri(c);
      c = '{0, 0, 0, 32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0};
      enqueue_tri(c);
      c = '{0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0};
      enqueue_tri(c);
      c = '{0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000};
      enqueue_tri(c);
      c = '{0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0};
      enqueue_tri(c);
      c = '{0, 0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0};
      enqueue_tri(c);
      c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
      enqueue_tri(c);
      c = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
      enqueue_tri(c);
      c = '{32'hffff_ffff, 0, 0, 0, 32'hffff_ffff, 0, 0, 0, 32'hffff_ffff};
      enqueue_tri(c);
      c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
      enqueue_tri(c);
      c = '{0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
      enqueue_tri(c);
      c = '{0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0, 32'h0001_0000, 32'h0001_0000, 0};
      enqueue_tri(c);
      c = '{0, 0, 0, 32'hffff_0000, 32'h0001_0000, 32'h0001_0000,
            32'h0001_0000, 32'hffff_0000, 32'h0001_0000};
      enqueue_tri(c);

      // Random: mostly proper faces, some collinear or repeated vertices.
      for (int k = 0; k < 450; k++) begin
         mode = $urandom_range(0, 3);
         foreach (c[i]) c[i] = rand_coord(mode);
         case ($urandom_range(0, 9))
            0: for (int i = 0; i < 3; i++) c[3 + i] = c[i];
            1: for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i];
            2: for (int i = 0; i < 3; i++) c[6 + i] = 2 * c[3 + i] - c[i];
            default: ;
         endcase
         enqueue_tri(c);
      end

      wait (tri_queue.size() < 300);
      hold_go = 1'b1;
      wait (tri_queue.size() < 80);
      calm = 1'b1;
      wait (tri_queue.size() == 0 && normal_queue.size() == 0);
      repeat (TAIL) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS triangle_face_normal_top");
      end else begin
         $display("FAIL triangle_face_normal_top");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("FAIL triangle_face_normal_top");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/tfn_pkg.sv
design/tfn_isqrt.sv
design/tfn_div.sv
design/triangle_face_normal_top.sv
bench/tb_triangle_face_normal_top.sv
